// ===== hw/rtl/fmdit_pkg.sv =====
// Shared types and constants for the FM chip dual interval timer.
// Holds the item and result words, register addresses and the line table.
// No dependencies.
`default_nettype none

package fmdit_pkg;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  // Chip register addresses that the timer block acts on.
  localparam logic [7:0] ADDR_PERIOD_A_HI = 8'h24;
  localparam logic [7:0] ADDR_PERIOD_A_LO = 8'h25;
  localparam logic [7:0] ADDR_PERIOD_B    = 8'h26;
  localparam logic [7:0] ADDR_MODE        = 8'h27;

  // Bit positions in the mode byte.
  localparam int unsigned ModeRunA     = 0;
  localparam int unsigned ModeRunB     = 1;
  localparam int unsigned ModeFlagEnA  = 2;
  localparam int unsigned ModeFlagEnB  = 3;
  localparam int unsigned ModeClearLsb = 4;
  localparam int unsigned ModeClearMsb = 5;

  // Top two mode bits select composite sine mode with this code.
  localparam logic [1:0] CSM_MODE = 2'b10;

  localparam int unsigned TimerASpan  = 1024;
  localparam int unsigned TimerBSpan  = 256;
  localparam int unsigned TimerBShift = 4;  // timer B counts in steps of 16 ticks

  localparam int unsigned TdataInWidth  = 24;
  localparam int unsigned TdataOutWidth = 16;

  typedef struct packed {
    logic       pcm;
    logic [7:0] data;
    logic [7:0] addr;
    cmd_e       cmd;
  } item_t;

  typedef struct packed {
    logic       run_b;
    logic       run_a;
    logic       keyon;
    logic [3:0] line;
    logic       lower;
    logic       raise;
    logic [1:0] flags;
  } result_t;

  // Interrupt controller line numbers chosen by the configuration register.
  function automatic logic [3:0] line_of(input logic [1:0] sel);
    logic [3:0] line;
    case (sel)
      2'd0:    line = 4'h3;
      2'd1:    line = 4'hd;
      2'd2:    line = 4'ha;
      2'd3:    line = 4'hc;
      default: line = 4'h3;
    endcase
    return line;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fmdit_timer_core.sv =====
// Timer A and timer B state with the per-word update logic.
// Depends on fmdit_pkg for the item and result types and the address map.
`default_nettype none

module fmdit_timer_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  fmdit_pkg::item_t      item_i,
  input  wire  [1:0]            irq_select_i,
  output fmdit_pkg::result_t    res_o
);

  logic [9:0]  period_a_q, period_a_d;
  logic [7:0]  period_b_q, period_b_d;
  logic [7:0]  mode_q, mode_d;
  logic [1:0]  flags_q, flags_d;
  logic [10:0] remain_a_q, remain_a_d;
  logic [12:0] remain_b_q, remain_b_d;
  logic        run_a_q, run_a_d;
  logic        run_b_q, run_b_d;

  logic [10:0] len_a;
  logic [12:0] len_b;
  logic        raise, lower, keyon;

  assign len_a = 11'(fmdit_pkg::TimerASpan) - {1'b0, period_a_q};
  assign len_b = {9'(fmdit_pkg::TimerBSpan) - {1'b0, period_b_q},
                  {fmdit_pkg::TimerBShift{1'b0}}};

  always_comb begin
    period_a_d = period_a_q;
    period_b_d = period_b_q;
    mode_d     = mode_q;
    flags_d    = flags_q;
    remain_a_d = remain_a_q;
    remain_b_d = remain_b_q;
    run_a_d    = run_a_q;
    run_b_d    = run_b_q;
    raise      = 1'b0;
    lower      = 1'b0;
    keyon      = 1'b0;

    if (item_i.cmd == fmdit_pkg::CMD_WRITE) begin
      case (item_i.addr)
        fmdit_pkg::ADDR_PERIOD_A_HI: period_a_d = {item_i.data, period_a_q[1:0]};
        fmdit_pkg::ADDR_PERIOD_A_LO: period_a_d = {period_a_q[9:2], item_i.data[1:0]};
        fmdit_pkg::ADDR_PERIOD_B:    period_b_d = item_i.data;
        fmdit_pkg::ADDR_MODE: begin
          mode_d  = item_i.data;
          flags_d = flags_q &
                    ~item_i.data[fmdit_pkg::ModeClearMsb:fmdit_pkg::ModeClearLsb];
          // A timer that is already counting keeps its count.
          if (item_i.data[fmdit_pkg::ModeRunA]) begin
            if (!run_a_q) begin
              run_a_d    = 1'b1;
              remain_a_d = len_a;
            end
          end else begin
            run_a_d = 1'b0;
          end
          if (item_i.data[fmdit_pkg::ModeRunB]) begin
            if (!run_b_q) begin
              run_b_d    = 1'b1;
              remain_b_d = len_b;
            end
          end else begin
            run_b_d = 1'b0;
          end
          lower = !item_i.data[fmdit_pkg::ModeRunA] && !item_i.data[fmdit_pkg::ModeRunB];
        end
        default: ;
      endcase
    end else begin
      // A count of one or zero expires on this tick.
      if (run_a_q) begin
        if (remain_a_q <= 11'd1) begin
          if (item_i.pcm || mode_q[fmdit_pkg::ModeFlagEnA]) raise = 1'b1;
          if (mode_q[fmdit_pkg::ModeFlagEnA]) flags_d[0] = 1'b1;
          remain_a_d = len_a;
          keyon      = (mode_q[7:6] == fmdit_pkg::CSM_MODE);
        end else begin
          remain_a_d = remain_a_q - 11'd1;
        end
      end
      if (run_b_q) begin
        if (remain_b_q <= 13'd1) begin
          if (item_i.pcm || mode_q[fmdit_pkg::ModeFlagEnB]) raise = 1'b1;
          if (mode_q[fmdit_pkg::ModeFlagEnB]) flags_d[1] = 1'b1;
          remain_b_d = len_b;
        end else begin
          remain_b_d = remain_b_q - 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_a_q <= '0;
      period_b_q <= '0;
      mode_q     <= '0;
      flags_q    <= '0;
      remain_a_q <= '0;
      remain_b_q <= '0;
      run_a_q    <= 1'b0;
      run_b_q    <= 1'b0;
    end else if (step_i) begin
      period_a_q <= period_a_d;
      period_b_q <= period_b_d;
      mode_q     <= mode_d;
      flags_q    <= flags_d;
      remain_a_q <= remain_a_d;
      remain_b_q <= remain_b_d;
      run_a_q    <= run_a_d;
      run_b_q    <= run_b_d;
    end
  end

  always_comb begin
    res_o.flags = flags_d;
    res_o.raise = raise;
    res_o.lower = lower;
    res_o.line  = fmdit_pkg::line_of(irq_select_i);
    res_o.keyon = keyon;
    res_o.run_a = run_a_d;
    res_o.run_b = run_b_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fm_chip_dual_interval_timer_top.sv =====
// Top level of the FM chip dual interval timer: stream ports, input and
// result registers. Depends on fmdit_pkg and fmdit_timer_core.
`default_nettype none

// Usage
// Each word on the slave stream is either a register write (tuser low) or
// one timer tick (tuser high). Writes to 0x24/0x25 set the 10-bit timer A
// period, 0x26 sets the timer B period and 0x27 is the mode byte, which
// clears flags and starts or stops the timers. Every accepted word gives
// exactly one result word on the master stream, carrying the status flags,
// the interrupt raise/lower pulses, the selected interrupt line number, the
// CSM key-on pulse and both run bits as they stand after that word.
// A word is captured into an input register, updated through the timer
// state by combinational logic, and lands in the result register once
// that register is free or being emptied. One word is taken every cycle
// while the receiver does not stall; the timer state is updated as each
// word moves from the input register to the result register.
// When the receiver stalls, the result register holds and the input
// register takes one more word before tready falls.
// The configuration channel writes the 2-bit line select; it is always
// ready and is meant to be written while no words are in flight.
// Reset clears the timers, flags, mode, periods and line select, and
// empties both registers.

module fm_chip_dual_interval_timer_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input words.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [fmdit_pkg::TdataInWidth-1:0]  s_axis_tdata,
                                     // register_address[7:0], write_data[15:8],
                                     // pcm_irq_request[16], zero above
  input  wire         s_axis_tuser,  // command: 0 write, 1 tick
  // Result words.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [fmdit_pkg::TdataOutWidth-1:0] m_axis_tdata,
                                     // status_flags[1:0], irq_raise[2],
                                     // irq_lower[3], irq_line[7:4],
                                     // csm_keyon[8], timer_a_running[9],
                                     // timer_b_running[10], zero above
  // Configuration.
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_data_i
);

  logic               in_valid_q;
  fmdit_pkg::item_t   item_q;
  logic               out_valid_q;
  fmdit_pkg::result_t res_q;
  fmdit_pkg::result_t res;
  logic [1:0]         irq_select_q;
  logic               advance;
  logic               in_take;

  // The input register moves on whenever the result register is free or
  // being emptied this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd  <= fmdit_pkg::cmd_e'(s_axis_tuser);
      item_q.addr <= s_axis_tdata[7:0];
      item_q.data <= s_axis_tdata[15:8];
      item_q.pcm  <= s_axis_tdata[16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_select_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      irq_select_q <= cfg_data_i;
    end
  end

  fmdit_timer_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (item_q),
    .irq_select_i (irq_select_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.run_b, res_q.run_a, res_q.keyon, res_q.line,
                          res_q.lower, res_q.raise, res_q.flags};

  // Raise happens only on ticks and lower only on mode writes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_q.raise && res_q.lower))
    else $error("irq raise and lower in the same result word");

  // Key-on comes only from a running timer A.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.keyon) |-> res_q.run_a)
    else $error("CSM key-on without timer A running");

  // A word parked in the input register behind a stalled result stays there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |=> in_valid_q)
    else $error("input word lost while result stalled");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the FM chip dual interval timer top level.
// Depends on fmdit_pkg and fm_chip_dual_interval_timer_top; it runs a table of
// directed words, then random timer programs checked against a local timer model.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fmdit_pkg::*;

  // Run shape. Each random phase runs under its own line selection.
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_WORDS   = 200;
  // Receiver hold-off used once to fill the block and stall its input.
  localparam int unsigned LONG_HOLD     = 300;
  // Cycles with no word moving on any channel before the run is abandoned.
  // This is many times the longest legal quiet stretch (the long hold).
  localparam int unsigned STALL_LIMIT   = 5000;

  // Interrupt controller line numbers, select 0 in the lowest nibble.
  localparam logic [15:0] LINE_NUMBERS = {4'hc, 4'ha, 4'hd, 4'h3};
  // Line selection for each random phase, phase 0 in the lowest bits. Both
  // extremes come up more than once.
  localparam logic [15:0] SELECT_PLAN  = {2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};

  // One row of the directed table: the word to send and, where the outcome
  // is plain from the register description, the result typed in by hand.
  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;

  // Timer model state, advanced once per accepted input word.
  logic [9:0]  tmr_period_a = '0;
  logic [7:0]  tmr_period_b = '0;
  logic [7:0]  tmr_mode = '0;
  logic [1:0]  tmr_flags = '0;
  logic [10:0] tmr_left_a = '0;
  logic [12:0] tmr_left_b = '0;
  logic        tmr_run_a = 1'b0;
  logic        tmr_run_b = 1'b0;
  logic [1:0]  line_sel = '0;

  // Results the block owes us, oldest first.
  result_t pending_results[$];
  directed_row_t directed_rows[$];

  int unsigned errors = 0;
  int unsigned live_words = 0;
  int unsigned results_seen = 0;
  int unsigned raises_seen = 0;
  int unsigned lowers_seen = 0;
  int unsigned keyons_seen = 0;
  int unsigned selects_written = 0;
  int unsigned long_holds = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;
  bit          long_hold_req = 1'b0;

  fm_chip_dual_interval_timer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Full timer A length: 1024 minus the period value, 1 to 1024 ticks.
  function automatic logic [10:0] reload_a();
    return 11'(TimerASpan) - {1'b0, tmr_period_a};
  endfunction

  // Full timer B length: 16 ticks per step, 256 minus the period value steps.
  function automatic logic [12:0] reload_b();
    return 13'((TimerBSpan - int'(tmr_period_b)) << TimerBShift);
  endfunction

  // Applies one input word to the timer model and returns the result word
  // that the block should send for it.
  function automatic result_t advance_timers(input item_t w);
    result_t r;
    logic    req;
    r = '0;
    if (w.cmd == CMD_WRITE) begin
      case (w.addr)
        ADDR_PERIOD_A_HI: tmr_period_a = {w.data, tmr_period_a[1:0]};
        ADDR_PERIOD_A_LO: tmr_period_a[1:0] = w.data[1:0];
        ADDR_PERIOD_B:    tmr_period_b = w.data;
        ADDR_MODE: begin
          tmr_mode = w.data;
          if (w.data[ModeClearLsb]) tmr_flags[0] = 1'b0;
          if (w.data[ModeClearMsb]) tmr_flags[1] = 1'b0;
          // A timer already counting keeps its count when started again.
          if (!w.data[ModeRunA]) begin
            tmr_run_a = 1'b0;
          end else if (!tmr_run_a) begin
            tmr_run_a = 1'b1;
            tmr_left_a = reload_a();
          end
          if (!w.data[ModeRunB]) begin
            tmr_run_b = 1'b0;
          end else if (!tmr_run_b) begin
            tmr_run_b = 1'b1;
            tmr_left_b = reload_b();
          end
          r.lower = !w.data[ModeRunA] && !w.data[ModeRunB];
        end
        default: ;
      endcase
    end else begin
      // A count of zero while running cannot arise, but is taken as expiry.
      if (tmr_run_a) begin
        if (tmr_left_a <= 11'd1) begin
          req = w.pcm;
          if (tmr_mode[ModeFlagEnA]) begin
            tmr_flags[0] = 1'b1;
            req = 1'b1;
          end
          r.raise = r.raise | req;
          tmr_left_a = reload_a();
          r.keyon = (tmr_mode[7:6] == CSM_MODE);
        end else begin
          tmr_left_a = tmr_left_a - 11'd1;
        end
      end
      if (tmr_run_b) begin
        if (tmr_left_b <= 13'd1) begin
          req = w.pcm;
          if (tmr_mode[ModeFlagEnB]) begin
            tmr_flags[1] = 1'b1;
            req = 1'b1;
          end
          r.raise = r.raise | req;
          tmr_left_b = reload_b();
        end else begin
          tmr_left_b = tmr_left_b - 13'd1;
        end
      end
    end
    r.flags = tmr_flags;
    r.line  = LINE_NUMBERS[line_sel * 4 +: 4];
    r.run_a = tmr_run_a;
    r.run_b = tmr_run_b;
    return r;
  endfunction

  function automatic item_t mk_item(input cmd_e c, input logic [7:0] a, input logic [7:0] d,
                                    input logic p);
    item_t w;
    w.cmd  = c;
    w.addr = a;
    w.data = d;
    w.pcm  = p;
    return w;
  endfunction

  // Hand-typed result for the directed part, which runs with line select 0.
  function automatic result_t want_of(input logic [1:0] flags, input logic raise,
                                      input logic lower, input logic keyon,
                                      input logic run_a, input logic run_b);
    result_t r;
    r.flags = flags;
    r.raise = raise;
    r.lower = lower;
    r.line  = 4'h3;
    r.keyon = keyon;
    r.run_a = run_a;
    r.run_b = run_b;
    return r;
  endfunction

  function automatic directed_row_t row(input item_t w, input bit typed, input result_t want);
    directed_row_t d;
    d.word  = w;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  // Gap length for either side: mostly none, often a few cycles, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!idle_en || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // Offers one word on the input stream after a random gap and waits until
  // the block takes it. The model is advanced at the accepting edge.
  task automatic send_word(input item_t w, input bit typed, input result_t want);
    int unsigned gap;
    result_t     model;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, w.pcm, w.data, w.addr};
    s_axis_tuser  <= w.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    model = advance_timers(w);
    pending_results.push_back(typed ? want : model);
    if (w.cmd == CMD_TICK || (w.addr >= ADDR_PERIOD_A_HI && w.addr <= ADDR_MODE)) begin
      live_words++;
    end
  endtask

  // Stops offering words and waits until every owed result is back, then lets
  // the two-stage pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_select(input logic [1:0] sel);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sel;
    do @(posedge clk_i); while (!cfg_ready_o);
    line_sel = sel;
    selects_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random stretch of stimulus. Most of the time it is a complete timer
  // program: periods set mostly short so that expiries are frequent, a mode
  // byte that usually runs at least one timer, then a burst of ticks with an
  // occasional register write falling while the timers count. The rest is
  // single words with random content, many at addresses the block ignores.
  task automatic play_burst();
    int unsigned span;
    int unsigned ticks;
    logic [9:0]  pa;
    logic [7:0]  mode;
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(3) != 0) begin
        span = ($urandom_range(3) == 0) ? $urandom_range(1024, 1) : $urandom_range(24, 1);
        pa = 10'(TimerASpan - span);
        send_word(mk_item(CMD_WRITE, ADDR_PERIOD_A_HI, pa[9:2], 1'($urandom)), 1'b0, '0);
        send_word(mk_item(CMD_WRITE, ADDR_PERIOD_A_LO, {6'($urandom), pa[1:0]},
                          1'($urandom)), 1'b0, '0);
      end
      if ($urandom_range(3) != 0) begin
        send_word(mk_item(CMD_WRITE, ADDR_PERIOD_B,
                          ($urandom_range(4) == 0) ? 8'($urandom)
                                                   : 8'hff - 8'($urandom_range(2)),
                          1'($urandom)), 1'b0, '0);
      end
      mode = 8'($urandom);
      if ($urandom_range(3) != 0) mode[1:0] = 2'($urandom_range(3, 1));
      if ($urandom_range(2) == 0) mode[7:6] = CSM_MODE;
      send_word(mk_item(CMD_WRITE, ADDR_MODE, mode, 1'($urandom)), 1'b0, '0);
      ticks = $urandom_range(48, 1);
      repeat (ticks) begin
        if ($urandom_range(9) == 0) begin
          send_word(mk_item(CMD_WRITE, ADDR_PERIOD_A_HI + 8'($urandom_range(3)),
                            8'($urandom), 1'($urandom)), 1'b0, '0);
        end else begin
          send_word(mk_item(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom)), 1'b0, '0);
        end
      end
    end else begin
      send_word(mk_item(cmd_e'($urandom_range(1)),
                        ($urandom_range(3) == 0) ? ADDR_PERIOD_A_HI + 8'($urandom_range(3))
                                                 : 8'($urandom),
                        8'($urandom), 1'($urandom)), 1'b0, '0);
    end
  endtask

  // Result receiver. It stalls at random, except in phases run without idling,
  // and once holds tready low for a long stretch on request so that the
  // block's two registers fill up and its input stalls.
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_req = 1'b0;
        long_holds++;
      end else if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (!idle_en || $urandom_range(99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall = pick_gap();
      end
    end
  end

  // Every result word is compared field by field with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[10:0]);
      if (pending_results.size() == 0) begin
        $display("%0t ns: result word with none owed, expected nothing, actual %h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status_flags", want.flags, got.flags);
        check_field("irq_raise", want.raise, got.raise);
        check_field("irq_lower", want.lower, got.lower);
        check_field("irq_line", want.line, got.line);
        check_field("csm_keyon", want.keyon, got.keyon);
        check_field("timer_a_running", want.run_a, got.run_a);
        check_field("timer_b_running", want.run_b, got.run_b);
        check_field("tdata padding", 0, m_axis_tdata[15:11]);
        results_seen++;
        if (got.raise) raises_seen++;
        if (got.lower) lowers_seen++;
        if (got.keyon) keyons_seen++;
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d results still owed",
               $time, STALL_LIMIT, pending_results.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned start;

    // Directed table. Rows with a typed result are the plain cases: the state
    // right after reset, writes the block ignores, the first start and the
    // first expiry of a one-tick timer A, and mode writes that stop both
    // timers. All other rows are checked against the timer model.
    // Tick right after reset: nothing runs, so the PCM request is ignored.
    directed_rows.push_back(row(mk_item(CMD_TICK, 8'h00, 8'h00, 1'b1), 1'b1,
                                want_of(2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));
    // Timer A period to its maximum, one tick, and timer B to 16 ticks.
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_PERIOD_A_HI, 8'hff, 1'b0), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_PERIOD_A_LO, 8'hff, 1'b1), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_PERIOD_B, 8'hff, 1'b0), 1'b0, '0));
    // Writes outside the timer registers change nothing.
    directed_rows.push_back(row(mk_item(CMD_WRITE, 8'h00, 8'hff, 1'b0), 1'b1,
                                want_of(2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(row(mk_item(CMD_WRITE, 8'hff, 8'h0f, 1'b1), 1'b1,
                                want_of(2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));
    // Start both timers with both flag enables; the PCM bit of a write is ignored.
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_MODE, 8'h0f, 1'b1), 1'b1,
                                want_of(2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1)));
    // Timer A expires on the first tick and sets its flag.
    directed_rows.push_back(row(mk_item(CMD_TICK, 8'h27, 8'h00, 1'b0), 1'b1,
                                want_of(2'd1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1)));
    // Start while running keeps the count; a period change waits for reload.
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_MODE, 8'h0f, 1'b0), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_PERIOD_A_HI, 8'h00, 1'b0), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_TICK, 8'hff, 8'hff, 1'b0), 1'b0, '0));
    // Clear both flags while both timers keep running.
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_MODE, 8'h3f, 1'b0), 1'b0, '0));
    // Stop both: the interrupt is lowered.
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_MODE, 8'h00, 1'b0), 1'b1,
                                want_of(2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_PERIOD_A_HI, 8'hff, 1'b0), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_PERIOD_A_LO, 8'h03, 1'b0), 1'b0, '0));
    // CSM mode with no flag enable: key-on pulse, interrupt only from PCM.
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_MODE, 8'h81, 1'b0), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_TICK, 8'h00, 8'hff, 1'b1), 1'b0, '0));
    // Top mode bits 11 and 01 are not CSM mode.
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_MODE, 8'hc1, 1'b0), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_TICK, 8'h24, 8'h55, 1'b0), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_MODE, 8'h41, 1'b0), 1'b0, '0));
    directed_rows.push_back(row(mk_item(CMD_TICK, 8'haa, 8'h00, 1'b1), 1'b0, '0));
    // A tick carrying a mode write's address and data is still just a tick.
    directed_rows.push_back(row(mk_item(CMD_TICK, ADDR_MODE, 8'h00, 1'b0), 1'b0, '0));
    // Stop both while clearing both flags.
    directed_rows.push_back(row(mk_item(CMD_WRITE, ADDR_MODE, 8'h30, 1'b0), 1'b1,
                                want_of(2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)));

    // Reset held low from the start, released on a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_select(2'd0);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    // Random phases, each under its own line selection. Phase 1 opens with
    // the long receiver hold; phase 3 runs both sides back to back.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_select(SELECT_PLAN[p * 2 +: 2]);
      idle_en = (p != 3);
      if (p == 1) long_hold_req = 1'b1;
      start = live_words;
      while (live_words - start < PHASE_WORDS) play_burst();
      drain();
    end
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d timer words, %0d results checked, %0d line select writes.",
             live_words, results_seen, selects_written);
    $display("Seen %0d interrupt raises, %0d lowers, %0d CSM key-ons, %0d long receiver hold.",
             raises_seen, lowers_seen, keyons_seen, long_holds);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
